[hw/rtl/ball_wall_bounce_step_assert.svh]
// assertion macros for the ball and wall bounce step block
// used by the top level through a plain include, no other dependency
`ifndef BALL_WALL_BOUNCE_STEP_ASSERT_SVH
`define BALL_WALL_BOUNCE_STEP_ASSERT_SVH

// same-cycle implication
`define BWB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bwb assertion failed");

// next-cycle implication
`define BWB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bwb assertion failed");

`endif

[hw/rtl/bwb_pkg.sv]
// shared types, constants and helpers for the ball and wall bounce step block
// no dependencies
`default_nettype none
package bwb_pkg;
   localparam int POS_W = 24;
   localparam int DIR_W = 16;
   localparam int CSR_W = 16;
   localparam int CSR_IDX_W = 3;
   localparam int POS_FRAC_DEFAULT = 8;
   localparam int DIR_FRAC_DEFAULT = 14;
   localparam int SPEED_FRAC = 8;
   localparam int SPEED_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_LEFT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOP    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BOTTOM = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED  = 3'd4;

   localparam logic [CSR_W-1:0] LEFT_RESET   = 16'd10;
   localparam logic [CSR_W-1:0] TOP_RESET    = 16'd10;
   localparam logic [CSR_W-1:0] RIGHT_RESET  = 16'd630;
   localparam logic [CSR_W-1:0] BOTTOM_RESET = 16'd470;
   localparam logic [CSR_W-1:0] SPEED_RESET  = 16'd1280;
   localparam logic signed [DIR_W-1:0] HEAD_X_RESET = 16'sd16384;

   localparam logic CMD_ADVANCE = 1'b0;
   localparam logic CMD_LOAD    = 1'b1;

   localparam logic [1:0] WALL_TOP    = 2'd0;
   localparam logic [1:0] WALL_RIGHT  = 2'd1;
   localparam logic [1:0] WALL_BOTTOM = 2'd2;
   localparam logic [1:0] WALL_LEFT   = 2'd3;

   typedef enum logic [0:0] {MAC_LOAD, MAC_SUB} mac_op_type;

   typedef struct packed {
      logic       en;
      mac_op_type op;
   } mac_ctl_type;

   function automatic logic signed [DIR_W-1:0] neg_sat(input logic signed [DIR_W-1:0] v);
      logic signed [DIR_W-1:0] r;
      if (v == {1'b1, {(DIR_W-1){1'b0}}}) begin
         r = {1'b0, {(DIR_W-1){1'b1}}};
      end else begin
         r = -v;
      end
      return r;
   endfunction
endpackage
`default_nettype wire

[hw/rtl/bwb_if.sv]
// valid/ready channel interfaces for requests, results and register writes
// depends on bwb_pkg
`default_nettype none
interface bwb_req_if;
   logic                             valid;
   logic                             ready;
   logic                             command;
   logic [bwb_pkg::POS_W-1:0]        load_x;
   logic [bwb_pkg::POS_W-1:0]        load_y;
   logic signed [bwb_pkg::DIR_W-1:0] load_dir_x;
   logic signed [bwb_pkg::DIR_W-1:0] load_dir_y;
   modport source (output valid, command, load_x, load_y, load_dir_x, load_dir_y,
                   input ready);
   modport sink (input valid, command, load_x, load_y, load_dir_x, load_dir_y,
                 output ready);
endinterface

interface bwb_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [bwb_pkg::POS_W-1:0]        pos_x;
   logic [bwb_pkg::POS_W-1:0]        pos_y;
   logic signed [bwb_pkg::DIR_W-1:0] dir_x;
   logic signed [bwb_pkg::DIR_W-1:0] dir_y;
   logic                             hit;
   logic [1:0]                       wall_index;
   modport source (output valid, pos_x, pos_y, dir_x, dir_y, hit, wall_index,
                   input ready);
   modport sink (input valid, pos_x, pos_y, dir_x, dir_y, hit, wall_index,
                 output ready);
endinterface

interface bwb_csr_if;
   logic                             valid;
   logic                             ready;
   logic [bwb_pkg::CSR_IDX_W-1:0]    index;
   logic [bwb_pkg::CSR_W-1:0]        data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[hw/rtl/bwb_mac.sv]
// shared signed multiply-accumulate unit, one product per cycle while enabled
// depends on bwb_pkg
`default_nettype none
module bwb_mac #(
   parameter int OP_W = 26
) (
   input  wire logic                      clock,
   input  wire bwb_pkg::mac_ctl_type      ctl,
   input  wire logic signed [OP_W-1:0]    op_a,
   input  wire logic signed [OP_W-1:0]    op_b,
   output logic signed [2*OP_W:0]         acc
);
   localparam int ACC_W = 2 * OP_W + 1;

   logic signed [2*OP_W-1:0] prod;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;

   always_comb begin
      prod = op_a * op_b;
      case (ctl.op)
         bwb_pkg::MAC_LOAD: acc_in = ACC_W'(prod);
         bwb_pkg::MAC_SUB:  acc_in = acc_ff - ACC_W'(prod);
         default:           acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;
endmodule
`default_nettype wire

[hw/rtl/ball_wall_bounce_step.sv]
// a load request goes straight to the result; an advance first forms the step products, then
// tests the walls in turn until one is hit, all on the single shared multiplier
// throughput: one request at a time, next request taken the cycle after the result leaves
// reset: synchronous, restores wall registers, speed, ball at origin heading along +x
// top level: sequencer around bwb_mac, depends on bwb_pkg, bwb_if and the assert header
`default_nettype none
`include "ball_wall_bounce_step_assert.svh"
module ball_wall_bounce_step #(
   parameter int POS_FRAC_BITS = bwb_pkg::POS_FRAC_DEFAULT,
   parameter int DIR_FRAC_BITS = bwb_pkg::DIR_FRAC_DEFAULT
) (
   input wire logic  clock,
   input wire logic  reset,
   bwb_req_if.sink   req_chan,
   bwb_rsp_if.source rsp_chan,
   bwb_csr_if.sink   csr_chan
);
   localparam int POS_W = bwb_pkg::POS_W;
   localparam int DIR_W = bwb_pkg::DIR_W;
   localparam int EDGE_W = bwb_pkg::CSR_W + POS_FRAC_BITS;
   localparam int STEP_SHIFT = DIR_FRAC_BITS + bwb_pkg::SPEED_FRAC - POS_FRAC_BITS;
   localparam int PROD_W = DIR_W + bwb_pkg::SPEED_W + 1;
   localparam int DW = PROD_W - STEP_SHIFT + 1;
   localparam int CW = ((EDGE_W > POS_W) ? EDGE_W : POS_W) + 2;
   localparam int OP_W0 = (CW > DW) ? CW : DW;
   localparam int OP_W = (OP_W0 > PROD_W / 2 + 1) ? OP_W0 : PROD_W / 2 + 1;
   localparam int ACC_W = 2 * OP_W + 1;
   localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

   typedef enum logic [1:0] {S_IDLE, S_DELTA, S_WALL, S_RESP} state_type;

   state_type state_ff, state_in;
   logic [2:0] step_ff, step_in;
   logic [1:0] wall_ff, wall_in;
   logic [POS_W-1:0] ball_x_ff, ball_x_in, ball_y_ff, ball_y_in;
   logic signed [DIR_W-1:0] head_x_ff, head_x_in, head_y_ff, head_y_in;
   logic hit_ff, hit_in;
   logic [1:0] widx_ff, widx_in;
   logic signed [OP_W-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic signed [ACC_W-1:0] den_ff, den_in, nt_ff, nt_in;
   logic [bwb_pkg::CSR_W-1:0] left_ff, top_ff, right_ff, bottom_ff, speed_ff;

   bwb_pkg::mac_ctl_type mac_ctl;
   logic signed [OP_W-1:0] op_a, op_b;
   logic signed [ACC_W-1:0] acc, rnd;
   logic signed [OP_W-1:0] l_s, t_s, r_s, b_s, sx, sy, ex, ey, wx, wy, rx, ry;
   logic signed [OP_W-1:0] x1, y1, spd;
   logic signed [OP_W:0] nx, ny;
   logic hit_now;

   function automatic logic strict_in(input logic signed [ACC_W-1:0] num,
                                      input logic signed [ACC_W-1:0] den);
      logic r;
      if (den > 0) begin
         r = (num > 0) && (num < den);
      end else begin
         r = (num < 0) && (num > den);
      end
      return r;
   endfunction

   function automatic logic [POS_W-1:0] sat_pos(input logic signed [OP_W:0] v);
      logic [POS_W-1:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > $signed({1'b0, (OP_W)'(POS_MAX)})) begin
         r = POS_MAX;
      end else begin
         r = v[POS_W-1:0];
      end
      return r;
   endfunction

   bwb_mac #(.OP_W(OP_W)) u_mac (
      .clock (clock),
      .ctl   (mac_ctl),
      .op_a  (op_a),
      .op_b  (op_b),
      .acc   (acc)
   );

   // wall geometry for the wall under test, step rounding, next position and hit test
   always_comb begin
      l_s = signed'(OP_W'({left_ff, {POS_FRAC_BITS{1'b0}}}));
      t_s = signed'(OP_W'({top_ff, {POS_FRAC_BITS{1'b0}}}));
      r_s = signed'(OP_W'({right_ff, {POS_FRAC_BITS{1'b0}}}));
      b_s = signed'(OP_W'({bottom_ff, {POS_FRAC_BITS{1'b0}}}));
      x1 = signed'(OP_W'(ball_x_ff));
      y1 = signed'(OP_W'(ball_y_ff));
      spd = signed'(OP_W'(speed_ff));
      sx = (wall_ff == bwb_pkg::WALL_TOP || wall_ff == bwb_pkg::WALL_LEFT) ? l_s : r_s;
      sy = (wall_ff == bwb_pkg::WALL_BOTTOM || wall_ff == bwb_pkg::WALL_LEFT) ? b_s : t_s;
      ex = (wall_ff == bwb_pkg::WALL_TOP || wall_ff == bwb_pkg::WALL_RIGHT) ? r_s : l_s;
      ey = (wall_ff == bwb_pkg::WALL_TOP || wall_ff == bwb_pkg::WALL_LEFT) ? t_s : b_s;
      wx = ex - sx;
      wy = ey - sy;
      rx = x1 - sx;
      ry = y1 - sy;
      rnd = (acc + (ACC_W'(1) <<< (STEP_SHIFT - 1))) >>> STEP_SHIFT;
      nx = (OP_W + 1)'(x1) + (OP_W + 1)'(dx_ff);
      ny = (OP_W + 1)'(y1) + (OP_W + 1)'(dy_ff);
      hit_now = (den_ff != 0) && strict_in(nt_ff, den_ff) && strict_in(acc, den_ff);
   end

   // shared unit schedule
   always_comb begin
      mac_ctl.en = 1'b0;
      mac_ctl.op = bwb_pkg::MAC_LOAD;
      op_a = '0;
      op_b = '0;
      case (state_ff)
         S_DELTA: begin
            mac_ctl.en = (step_ff != 3'd2);
            op_a = (step_ff == 3'd0) ? OP_W'(head_x_ff) : OP_W'(head_y_ff);
            op_b = spd;
         end
         S_WALL: begin
            mac_ctl.en = (step_ff != 3'd6);
            mac_ctl.op = step_ff[0] ? bwb_pkg::MAC_SUB : bwb_pkg::MAC_LOAD;
            case (step_ff)
               3'd0: begin op_a = wy; op_b = dx_ff; end
               3'd1: begin op_a = wx; op_b = dy_ff; end
               3'd2: begin op_a = wx; op_b = ry; end
               3'd3: begin op_a = wy; op_b = rx; end
               3'd4: begin op_a = dx_ff; op_b = ry; end
               3'd5: begin op_a = dy_ff; op_b = rx; end
               default: begin op_a = '0; op_b = '0; end
            endcase
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      wall_in = wall_ff;
      ball_x_in = ball_x_ff;
      ball_y_in = ball_y_ff;
      head_x_in = head_x_ff;
      head_y_in = head_y_ff;
      hit_in = hit_ff;
      widx_in = widx_ff;
      dx_in = dx_ff;
      dy_in = dy_ff;
      den_in = den_ff;
      nt_in = nt_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               hit_in = 1'b0;
               widx_in = bwb_pkg::WALL_TOP;
               step_in = '0;
               wall_in = bwb_pkg::WALL_TOP;
               if (req_chan.command == bwb_pkg::CMD_LOAD) begin
                  ball_x_in = req_chan.load_x;
                  ball_y_in = req_chan.load_y;
                  head_x_in = req_chan.load_dir_x;
                  head_y_in = req_chan.load_dir_y;
                  state_in = S_RESP;
               end else begin
                  state_in = S_DELTA;
               end
            end
         end
         S_DELTA: begin
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd1) begin
               dx_in = OP_W'(rnd);
            end
            if (step_ff == 3'd2) begin
               dy_in = OP_W'(rnd);
               step_in = '0;
               state_in = S_WALL;
            end
         end
         S_WALL: begin
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd2) begin
               den_in = acc;
            end
            if (step_ff == 3'd4) begin
               nt_in = acc;
            end
            if (step_ff == 3'd6) begin
               step_in = '0;
               if (hit_now) begin
                  hit_in = 1'b1;
                  widx_in = wall_ff;
                  if (wall_ff == bwb_pkg::WALL_TOP || wall_ff == bwb_pkg::WALL_BOTTOM) begin
                     head_y_in = bwb_pkg::neg_sat(head_y_ff);
                  end else begin
                     head_x_in = bwb_pkg::neg_sat(head_x_ff);
                  end
                  state_in = S_RESP;
               end else if (wall_ff == bwb_pkg::WALL_LEFT) begin
                  ball_x_in = sat_pos(nx);
                  ball_y_in = sat_pos(ny);
                  state_in = S_RESP;
               end else begin
                  wall_in = wall_ff + 2'd1;
               end
            end
         end
         S_RESP: begin
            if (rsp_chan.ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff <= '0;
         wall_ff <= '0;
         ball_x_ff <= '0;
         ball_y_ff <= '0;
         head_x_ff <= bwb_pkg::HEAD_X_RESET;
         head_y_ff <= '0;
         hit_ff <= 1'b0;
         widx_ff <= '0;
         left_ff <= bwb_pkg::LEFT_RESET;
         top_ff <= bwb_pkg::TOP_RESET;
         right_ff <= bwb_pkg::RIGHT_RESET;
         bottom_ff <= bwb_pkg::BOTTOM_RESET;
         speed_ff <= bwb_pkg::SPEED_RESET;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         wall_ff <= wall_in;
         ball_x_ff <= ball_x_in;
         ball_y_ff <= ball_y_in;
         head_x_ff <= head_x_in;
         head_y_ff <= head_y_in;
         hit_ff <= hit_in;
         widx_ff <= widx_in;
         if (csr_chan.valid) begin
            case (csr_chan.index)
               bwb_pkg::CSR_LEFT:   left_ff <= csr_chan.data;
               bwb_pkg::CSR_TOP:    top_ff <= csr_chan.data;
               bwb_pkg::CSR_RIGHT:  right_ff <= csr_chan.data;
               bwb_pkg::CSR_BOTTOM: bottom_ff <= csr_chan.data;
               bwb_pkg::CSR_SPEED:  speed_ff <= csr_chan.data;
               default: begin
               end
            endcase
         end
      end
      dx_ff <= dx_in;
      dy_ff <= dy_in;
      den_ff <= den_in;
      nt_ff <= nt_in;
   end

   assign req_chan.ready = (state_ff == S_IDLE);
   assign csr_chan.ready = 1'b1;
   assign rsp_chan.valid = (state_ff == S_RESP);
   assign rsp_chan.pos_x = ball_x_ff;
   assign rsp_chan.pos_y = ball_y_ff;
   assign rsp_chan.dir_x = head_x_ff;
   assign rsp_chan.dir_y = head_y_ff;
   assign rsp_chan.hit = hit_ff;
   assign rsp_chan.wall_index = widx_ff;

   `BWB_ASSERT_NEXT(a_busy_after_req, clock, reset, req_chan.valid && req_chan.ready, !req_chan.ready)
   `BWB_ASSERT_NOW(a_one_at_a_time, clock, reset, rsp_chan.valid, !req_chan.ready)
   `BWB_ASSERT_NOW(a_miss_wall_zero, clock, reset, rsp_chan.valid && !rsp_chan.hit, rsp_chan.wall_index == bwb_pkg::WALL_TOP)
endmodule
`default_nettype wire

[tb/sv/bwb_tb_pkg.sv]
// scoreboard class for the ball and wall bounce step testbench: predicts each result
// from its own copy of the walls, speed and ball state; depends on bwb_pkg
package bwb_tb_pkg;
   import bwb_pkg::*;

   typedef struct packed {
      logic [POS_W-1:0]        pos_x;
      logic [POS_W-1:0]        pos_y;
      logic signed [DIR_W-1:0] dir_x;
      logic signed [DIR_W-1:0] dir_y;
      logic                    hit;
      logic [1:0]              wall_index;
   } ball_state_t;

   class bounce_scoreboard;
      logic [CSR_W-1:0]        edge_l, edge_t, edge_r, edge_b, speed;
      logic [POS_W-1:0]        bx, by;
      logic signed [DIR_W-1:0] hx, hy;
      ball_state_t             pending[$];
      int                      mismatches;
      int                      checked;
      int                      hits;

      function new();
         edge_l = LEFT_RESET;
         edge_t = TOP_RESET;
         edge_r = RIGHT_RESET;
         edge_b = BOTTOM_RESET;
         speed = SPEED_RESET;
         bx = '0;
         by = '0;
         hx = HEAD_X_RESET;
         hy = '0;
         mismatches = 0;
         checked = 0;
         hits = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] val);
         case (idx)
            CSR_LEFT: edge_l = val;
            CSR_TOP: edge_t = val;
            CSR_RIGHT: edge_r = val;
            CSR_BOTTOM: edge_b = val;
            CSR_SPEED: speed = val;
            default: ;
         endcase
      endfunction

      function longint step_delta(logic signed [DIR_W-1:0] d);
         longint p;
         p = longint'(d) * longint'({1'b0, speed});
         return (p + 64'sd8192) >>> 14;
      endfunction

      function bit strictly_in(longint n, longint d);
         if (d > 0) return n > 0 && n < d;
         return n < 0 && n > d;
      endfunction

      function logic [POS_W-1:0] clamp_pos(longint v);
         if (v < 0) return '0;
         if (v > 64'sd16777215) return '1;
         return v[POS_W-1:0];
      endfunction

      function logic signed [DIR_W-1:0] negate(logic signed [DIR_W-1:0] v);
         return (v == -16'sd32768) ? 16'sd32767 : -v;
      endfunction

      function void note_request(logic cmd, logic [POS_W-1:0] lx, logic [POS_W-1:0] ly,
                                 logic signed [DIR_W-1:0] ldx,
                                 logic signed [DIR_W-1:0] ldy);
         ball_state_t e;
         longint dx, dy, l, t, r, b, wx, wy, rx, ry, den, nt, nu;
         longint sx[4], sy[4], ex[4], ey[4];
         bit found;
         logic [1:0] w;
         found = 0;
         w = WALL_TOP;
         if (cmd == CMD_LOAD) begin
            bx = lx;
            by = ly;
            hx = ldx;
            hy = ldy;
         end else begin
            dx = step_delta(hx);
            dy = step_delta(hy);
            l = longint'(edge_l) << 8;
            t = longint'(edge_t) << 8;
            r = longint'(edge_r) << 8;
            b = longint'(edge_b) << 8;
            sx = '{l, r, r, l};
            sy = '{t, t, b, b};
            ex = '{r, r, l, l};
            ey = '{t, b, b, t};
            for (int i = 0; i < 4; i++) begin
               if (!found) begin
                  wx = ex[i] - sx[i];
                  wy = ey[i] - sy[i];
                  ry = longint'(by) - sy[i];
                  rx = longint'(bx) - sx[i];
                  den = wy * dx - wx * dy;
                  nt = wx * ry - wy * rx;
                  nu = dx * ry - dy * rx;
                  if (den != 0 && strictly_in(nt, den) && strictly_in(nu, den)) begin
                     found = 1;
                     w = i[1:0];
                  end
               end
            end
            if (found) begin
               hits++;
               if (w == WALL_TOP || w == WALL_BOTTOM) hy = negate(hy);
               else hx = negate(hx);
            end else begin
               bx = clamp_pos(longint'(bx) + dx);
               by = clamp_pos(longint'(by) + dy);
            end
         end
         e.pos_x = bx;
         e.pos_y = by;
         e.dir_x = hx;
         e.dir_y = hy;
         e.hit = found;
         e.wall_index = found ? w : WALL_TOP;
         pending.push_back(e);
      endfunction

      function void check_result(ball_state_t got);
         ball_state_t e;
         checked++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
            return;
         end
         e = pending.pop_front();
         if (got !== e) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p got %p", e, got);
         end
      endfunction
   endclass
endpackage

[tb/sv/testbench.sv]
// top of the ball and wall bounce step testbench: clock, reset, request, result and
// register drivers; depends on bwb_pkg, bwb_if, bwb_tb_pkg and the block itself
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import bwb_pkg::*;
   import bwb_tb_pkg::*;

   logic clock = 0;
   logic reset = 1;
   int   cycle = 0;
   int   send_idle = 0;
   int   recv_stall = 0;
   bounce_scoreboard sb;

   bwb_req_if req_chan();
   bwb_rsp_if rsp_chan();
   bwb_csr_if csr_chan();

   ball_wall_bounce_step dut (
      .clock(clock), .reset(reset),
      .req_chan(req_chan), .rsp_chan(rsp_chan), .csr_chan(csr_chan)
   );

   always #6 clock = ~clock;

   initial begin
      req_chan.valid = 0;
      req_chan.command = 0;
      req_chan.load_x = 0;
      req_chan.load_y = 0;
      req_chan.load_dir_x = 0;
      req_chan.load_dir_y = 0;
      rsp_chan.ready = 0;
      csr_chan.valid = 0;
      csr_chan.index = 0;
      csr_chan.data = 0;
   end

   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle > 900000) begin
         $display("tb: failure");
         $finish;
      end
   end

   // result side: random stall, check on handshake
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready)
            sb.check_result('{rsp_chan.pos_x, rsp_chan.pos_y, rsp_chan.dir_x,
                              rsp_chan.dir_y, rsp_chan.hit, rsp_chan.wall_index});
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall);
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] val);
      csr_chan.valid <= 1;
      csr_chan.index <= idx;
      csr_chan.data <= val;
      do @(posedge clock); while (!csr_chan.ready);
      sb.write_reg(idx, val);
      csr_chan.valid <= 0;
   endtask

   task automatic send(logic cmd, logic [POS_W-1:0] lx, logic [POS_W-1:0] ly,
                       logic signed [DIR_W-1:0] ldx, logic signed [DIR_W-1:0] ldy);
      while ($urandom_range(99) < send_idle) begin
         req_chan.valid <= 0;
         @(posedge clock);
      end
      req_chan.valid <= 1;
      req_chan.command <= cmd;
      req_chan.load_x <= lx;
      req_chan.load_y <= ly;
      req_chan.load_dir_x <= ldx;
      req_chan.load_dir_y <= ldy;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_request(cmd, lx, ly, ldx, ldy);
   endtask

   task automatic advance();
      send(CMD_ADVANCE, POS_W'($urandom), POS_W'($urandom), DIR_W'($urandom),
           DIR_W'($urandom));
   endtask

   task automatic load_unit(logic [POS_W-1:0] lx, logic [POS_W-1:0] ly);
      int a;
      logic signed [DIR_W-1:0] c, s;
      a = $urandom_range(3);
      c = DIR_W'($urandom_range(16384));
      s = (c > 11585) ? 16'sd16384 - (c - 16'sd11585) : 16'sd11585;
      if (a[0]) c = -c;
      if (a[1]) s = -s;
      send(CMD_LOAD, lx, ly, c, s);
   endtask

   task automatic drain();
      req_chan.valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic random_phase(int n);
      logic [CSR_W-1:0] l, t;
      for (int i = 0; i < n; i++) begin
         l = sb.edge_l;
         t = sb.edge_t;
         if ($urandom_range(9) == 0)
            send(CMD_LOAD, POS_W'($urandom), POS_W'($urandom), DIR_W'($urandom),
                 DIR_W'($urandom));
         else if ($urandom_range(14) == 0)
            load_unit({l + 16'($urandom_range(40)), 8'($urandom)},
                      {t + 16'($urandom_range(40)), 8'($urandom)});
         else
            advance();
      end
   endtask

   initial begin
      sb = new();
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: reset state, then each wall, corners and field extremes
      advance();
      send(CMD_LOAD, {16'd20, 8'd0}, {16'd11, 8'd0}, 16'sd0, -16'sd16384);
      advance();
      advance();
      send(CMD_LOAD, {16'd625, 8'd0}, {16'd200, 8'd0}, 16'sd16384, 16'sd0);
      advance();
      send(CMD_LOAD, {16'd300, 8'd0}, {16'd466, 8'd128}, 16'sd0, 16'sd16384);
      advance();
      send(CMD_LOAD, {16'd12, 8'd0}, {16'd200, 8'd0}, -16'sd16384, 16'sd0);
      advance();
      send(CMD_LOAD, {16'd12, 8'd0}, {16'd12, 8'd0}, -16'sd11585, -16'sd11585);
      advance();
      send(CMD_LOAD, 24'hFFFFFF, 24'hFFFFFF, 16'sd32767, 16'sd32767);
      advance();
      send(CMD_LOAD, 24'h0, 24'h0, -16'sd32768, -16'sd32768);
      advance();
      send(CMD_LOAD, {16'd640, 8'd0}, {16'd5, 8'd0}, -16'sd32768, 16'sd16384);
      advance();
      advance();
      drain();
      // degenerate and reversed rectangles at maximum speed
      write_reg(CSR_SPEED, 16'hFFFF);
      write_reg(CSR_LEFT, 16'd100);
      write_reg(CSR_RIGHT, 16'd100);
      send(CMD_LOAD, {16'd90, 8'd0}, {16'd200, 8'd0}, 16'sd16384, 16'sd0);
      advance();
      drain();
      write_reg(CSR_LEFT, 16'd500);
      write_reg(CSR_TOP, 16'd400);
      write_reg(CSR_BOTTOM, 16'd50);
      drain();
      write_reg(CSR_RIGHT, 16'd100);
      send(CMD_LOAD, {16'd300, 8'd0}, {16'd200, 8'd0}, 16'sd11585, 16'sd11585);
      advance();
      advance();
      drain();
      // random phases with settings and idling patterns
      for (int ph = 0; ph < 8; ph++) begin
         send_idle = (ph % 4 == 1) ? 45 : (ph % 4 == 3) ? 22 : 0;
         recv_stall = (ph % 4 == 2) ? 45 : (ph % 4 == 3) ? 22 : 0;
         case (ph)
            0: begin write_reg(CSR_LEFT, 16'd10); write_reg(CSR_TOP, 16'd10);
                     write_reg(CSR_RIGHT, 16'd60); write_reg(CSR_BOTTOM, 16'd50);
                     write_reg(CSR_SPEED, 16'd1280); end
            1: write_reg(CSR_SPEED, 16'd0);
            2: begin write_reg(CSR_SPEED, 16'd600); write_reg(CSR_LEFT, 16'd0);
                     write_reg(CSR_TOP, 16'd0); end
            3: begin write_reg(CSR_RIGHT, 16'hFFFF); write_reg(CSR_BOTTOM, 16'hFFFF);
                     write_reg(CSR_SPEED, 16'hFFFF); end
            4: begin write_reg(CSR_LEFT, 16'hFFF0); write_reg(CSR_TOP, 16'hFFF0);
                     write_reg(CSR_SPEED, 16'd1024); end
            5: begin write_reg(CSR_LEFT, 16'd40); write_reg(CSR_RIGHT, 16'd20);
                     write_reg(CSR_TOP, 16'd5); write_reg(CSR_BOTTOM, 16'd30); end
            default: begin write_reg(CSR_LEFT, CSR_W'($urandom_range(50)));
                     write_reg(CSR_TOP, CSR_W'($urandom_range(50)));
                     write_reg(CSR_RIGHT, CSR_W'(60 + $urandom_range(50)));
                     write_reg(CSR_BOTTOM, CSR_W'(60 + $urandom_range(50)));
                     write_reg(CSR_SPEED, CSR_W'($urandom_range(4000))); end
         endcase
         random_phase(150);
         drain();
      end
      $display("covered %0d results, %0d wall reflections, over 8 register settings",
               sb.checked, sb.hits);
      $display("idling phases: none, sender, receiver and both");
      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
